// ===== sv/pwi_pkg.sv =====
// ----------------------------------------------------------------------------
// pwi_pkg
// Shared types and codes for the windowed-integral PID block.
// ----------------------------------------------------------------------------
package pwi_pkg;

   localparam int DATA_W   = 16;
   localparam int RESULT_W = 32;
   localparam int CSR_W    = 32;
   localparam int ADDR_W   = 4;

   localparam logic OP_COMPUTE = 1'b0;
   localparam logic OP_CLEAR   = 1'b1;

   localparam logic [1:0] REG_GAIN_P = 2'd0;
   localparam logic [1:0] REG_GAIN_I = 2'd1;
   localparam logic [1:0] REG_GAIN_D = 2'd2;

   typedef struct packed {
      logic [DATA_W-1:0] proportional;
      logic [DATA_W-1:0] integral;
      logic [DATA_W-1:0] derivative;
   } gains_type;

   typedef struct packed {
      logic                     valid;
      logic signed [DATA_W-1:0] err;
      logic signed [DATA_W-1:0] deriv;
   } stage_type;

endpackage

// ===== sv/pwi_csr.sv =====
// ----------------------------------------------------------------------------
// pwi_csr
// Gain registers behind the APB-style configuration port.
// ----------------------------------------------------------------------------
module pwi_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [pwi_pkg::ADDR_W-1:0]  paddr,
   input  logic [pwi_pkg::CSR_W-1:0]   pwdata,
   output logic [pwi_pkg::CSR_W-1:0]   prdata,
   output logic                        pready,
   output pwi_pkg::gains_type          gains
);

   pwi_pkg::gains_type gains_ff, gains_in;
   logic               write_en;
   logic [1:0]         reg_index;

   assign pready    = 1'b1;
   assign reg_index = paddr[3:2];
   assign write_en  = psel && penable && pwrite && pready;

   always_comb begin
      gains_in = gains_ff;
      if (write_en) begin
         unique case (reg_index)
            pwi_pkg::REG_GAIN_P: gains_in.proportional = pwdata[pwi_pkg::DATA_W-1:0];
            pwi_pkg::REG_GAIN_I: gains_in.integral     = pwdata[pwi_pkg::DATA_W-1:0];
            pwi_pkg::REG_GAIN_D: gains_in.derivative   = pwdata[pwi_pkg::DATA_W-1:0];
            default:             gains_in              = gains_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         pwi_pkg::REG_GAIN_P: prdata = {16'd0, gains_ff.proportional};
         pwi_pkg::REG_GAIN_I: prdata = {16'd0, gains_ff.integral};
         pwi_pkg::REG_GAIN_D: prdata = {16'd0, gains_ff.derivative};
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff <= '0;
      end else begin
         gains_ff <= gains_in;
      end
   end

   assign gains = gains_ff;

endmodule

// ===== sv/pwi_front.sv =====
// ----------------------------------------------------------------------------
// pwi_front
// Error, delay line, window sum and derivative; feeds the multiply stage.
// ----------------------------------------------------------------------------
module pwi_front #(
   parameter int WINDOW_LEN = 8,
   parameter int SUM_W      = 16 + $clog2(WINDOW_LEN)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load,
   input  logic                              advance,
   input  logic                              operation,
   input  logic [pwi_pkg::DATA_W-1:0]        target_value,
   input  logic [pwi_pkg::DATA_W-1:0]        measured_value,
   output pwi_pkg::stage_type                stage,
   output logic signed [SUM_W-1:0]           stage_sum
);

   logic signed [pwi_pkg::DATA_W-1:0] hist_ff [WINDOW_LEN];
   logic signed [pwi_pkg::DATA_W-1:0] hist_in [WINDOW_LEN];
   logic signed [SUM_W-1:0]           sum_ff, sum_in;
   pwi_pkg::stage_type                stage_ff, stage_in;
   logic signed [SUM_W-1:0]           stage_sum_ff, stage_sum_in;
   logic signed [pwi_pkg::DATA_W-1:0] err;
   logic signed [pwi_pkg::DATA_W-1:0] diff;
   logic signed [SUM_W-1:0]           sum_next;
   logic                              take_compute;

   assign err          = $signed(measured_value - target_value);
   assign diff         = err - hist_ff[0];
   assign sum_next     = sum_ff + SUM_W'(err) - SUM_W'(hist_ff[WINDOW_LEN-1]);
   assign take_compute = load && (operation == pwi_pkg::OP_COMPUTE);

   always_comb begin
      hist_in      = hist_ff;
      sum_in       = sum_ff;
      stage_in     = stage_ff;
      stage_sum_in = stage_sum_ff;
      if (advance) begin
         stage_in.valid = 1'b0;
      end
      if (load) begin
         stage_in.valid = take_compute;
         if (operation == pwi_pkg::OP_CLEAR) begin
            for (int i = 0; i < WINDOW_LEN; i++) begin
               hist_in[i] = '0;
            end
            sum_in = '0;
         end else begin
            for (int i = 1; i < WINDOW_LEN; i++) begin
               hist_in[i] = hist_ff[i-1];
            end
            hist_in[0]     = err;
            sum_in         = sum_next;
            stage_in.err   = err;
            stage_in.deriv = (hist_ff[0] != '0) ? diff : '0;
            stage_sum_in   = sum_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_LEN; i++) begin
            hist_ff[i] <= '0;
         end
         sum_ff         <= '0;
         stage_ff.valid <= 1'b0;
      end else begin
         hist_ff        <= hist_in;
         sum_ff         <= sum_in;
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.err   <= stage_in.err;
      stage_ff.deriv <= stage_in.deriv;
      stage_sum_ff   <= stage_sum_in;
   end

   assign stage     = stage_ff;
   assign stage_sum = stage_sum_ff;

endmodule

// ===== sv/pwi_mac.sv =====
// ----------------------------------------------------------------------------
// pwi_mac
// Three gain products summed into the result register.
// ----------------------------------------------------------------------------
module pwi_mac #(
   parameter int SUM_W = 19
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  pwi_pkg::gains_type                  gains,
   input  pwi_pkg::stage_type                  stage,
   input  logic signed [SUM_W-1:0]             stage_sum,
   output logic                                result_valid,
   output logic [pwi_pkg::RESULT_W-1:0]        result_value
);

   logic signed [pwi_pkg::DATA_W:0]         prod_p;
   logic signed [pwi_pkg::DATA_W+SUM_W:0]   prod_i;
   logic signed [pwi_pkg::DATA_W:0]         prod_d;
   logic signed [2*pwi_pkg::DATA_W:0]       wide_p;
   logic signed [2*pwi_pkg::DATA_W:0]       wide_d;
   logic [pwi_pkg::RESULT_W-1:0]            acc;
   logic                                    valid_ff, valid_in;
   logic [pwi_pkg::RESULT_W-1:0]            value_ff, value_in;

   assign prod_p = $signed({1'b0, gains.proportional});
   assign prod_d = $signed({1'b0, gains.derivative});
   assign wide_p = prod_p * stage.err;
   assign wide_d = prod_d * stage.deriv;
   assign prod_i = $signed({1'b0, gains.integral}) * stage_sum;

   assign acc = wide_p[pwi_pkg::RESULT_W-1:0] + prod_i[pwi_pkg::RESULT_W-1:0]
              + wide_d[pwi_pkg::RESULT_W-1:0];

   assign valid_in = load ? stage.valid : valid_ff;
   assign value_in = (load && stage.valid) ? acc : value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

   assign result_valid = valid_ff;
   assign result_value = value_ff;

endmodule

// ===== sv/pid_windowed_integral.sv =====
// ----------------------------------------------------------------------------
// pid_windowed_integral
// PID controller with a sliding-window integral over the last WINDOW_LEN errors.
//
// Requests arrive on the req_ valid/ready channel: a compute request carries a
// set point and a measured value and yields one control value on the rsp_
// channel; a clear request empties the error history and the window sum and
// yields nothing. Gains are written over the APB-style port at byte addresses
// 0, 4 and 8 (proportional, integral, derivative, units of 0.01).
// From acceptance to rsp_valid the input stage registers the error, window sum
// and derivative, then the result register the three gain products summed.
// Throughput is one request per cycle while the receiver takes results; the
// delay line and window sum are updated as each request is accepted.
// When the receiver stalls, the result register holds and the middle stage
// still takes one more request; req_ready drops only when both are full.
// Reset clears the history, the sum, the gains and both valid flags.
// ----------------------------------------------------------------------------
module pid_windowed_integral #(
   parameter int WINDOW_LEN = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_operation,
   input  logic [pwi_pkg::DATA_W-1:0]         req_target_value,
   input  logic [pwi_pkg::DATA_W-1:0]         req_measured_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [pwi_pkg::RESULT_W-1:0] rsp_control_value,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [pwi_pkg::ADDR_W-1:0]         paddr,
   input  logic [pwi_pkg::CSR_W-1:0]          pwdata,
   output logic [pwi_pkg::CSR_W-1:0]          prdata,
   output logic                               pready
);

   localparam int SUM_W = 16 + $clog2(WINDOW_LEN);

   pwi_pkg::gains_type          gains;
   pwi_pkg::stage_type          stage;
   logic signed [SUM_W-1:0]     stage_sum;
   logic                        out_advance;
   logic                        req_take;
   logic [pwi_pkg::RESULT_W-1:0] result_value;

   assign out_advance = !rsp_valid || rsp_ready;
   assign req_ready   = !stage.valid || out_advance;
   assign req_take    = req_valid && req_ready;

   pwi_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .gains   (gains)
   );

   pwi_front #(
      .WINDOW_LEN (WINDOW_LEN),
      .SUM_W      (SUM_W)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .load           (req_take),
      .advance        (out_advance),
      .operation      (req_operation),
      .target_value   (req_target_value),
      .measured_value (req_measured_value),
      .stage          (stage),
      .stage_sum      (stage_sum)
   );

   pwi_mac #(
      .SUM_W (SUM_W)
   ) u_mac (
      .clock        (clock),
      .reset        (reset),
      .load         (out_advance),
      .gains        (gains),
      .stage        (stage),
      .stage_sum    (stage_sum),
      .result_valid (rsp_valid),
      .result_value (result_value)
   );

   assign rsp_control_value = $signed(result_value);

   a_clear_no_stage: assert property (@(posedge clock) disable iff (reset)
      req_take && (req_operation == pwi_pkg::OP_CLEAR) |=> !stage.valid)
      else $error("clear request entered the multiply stage");

   a_compute_staged: assert property (@(posedge clock) disable iff (reset)
      req_take && (req_operation == pwi_pkg::OP_COMPUTE) |=> stage.valid)
      else $error("compute request lost at the input stage");

   a_stage_to_rsp: assert property (@(posedge clock) disable iff (reset)
      stage.valid && out_advance |=> rsp_valid)
      else $error("staged request did not reach the result register");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with an empty result register");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the windowed-integral PID controller.
//
// A driver feeds compute and clear requests from a pending queue; each
// accepted request runs through a local model of the error history, window
// sum and derivative; a compute queues its expected control value. A monitor
// compares every delivered control value with the oldest expectation. Gains
// are rewritten over the APB-style port between phases, while the block is
// idle, and both channels stall at random with varying duty.
// ----------------------------------------------------------------------------
module tb;

   localparam int WINDOW_LEN = 8;

   localparam logic [pwi_pkg::ADDR_W-1:0] ADDR_GAIN_P   = {pwi_pkg::REG_GAIN_P, 2'b00};
   localparam logic [pwi_pkg::ADDR_W-1:0] ADDR_GAIN_I   = {pwi_pkg::REG_GAIN_I, 2'b00};
   localparam logic [pwi_pkg::ADDR_W-1:0] ADDR_GAIN_D   = {pwi_pkg::REG_GAIN_D, 2'b00};
   localparam logic [pwi_pkg::ADDR_W-1:0] ADDR_UNMAPPED = {2'd3, 2'b00};

   typedef struct packed {
      logic                       op;
      logic [pwi_pkg::DATA_W-1:0] target;
      logic [pwi_pkg::DATA_W-1:0] measured;
   } request_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_ready;
   logic                                 req_operation = pwi_pkg::OP_COMPUTE;
   logic [pwi_pkg::DATA_W-1:0]           req_target_value = '0;
   logic [pwi_pkg::DATA_W-1:0]           req_measured_value = '0;
   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b0;
   logic signed [pwi_pkg::RESULT_W-1:0]  rsp_control_value;
   logic                                 psel = 1'b0;
   logic                                 penable = 1'b0;
   logic                                 pwrite = 1'b0;
   logic [pwi_pkg::ADDR_W-1:0]           paddr = '0;
   logic [pwi_pkg::CSR_W-1:0]            pwdata = '0;
   logic [pwi_pkg::CSR_W-1:0]            prdata;
   logic                                 pready;

   request_type                          pending_requests[$];
   logic signed [pwi_pkg::RESULT_W-1:0]  expected_controls[$];
   request_type                          next_req;
   logic signed [pwi_pkg::RESULT_W-1:0]  want;

   logic signed [pwi_pkg::DATA_W-1:0]    err_hist[WINDOW_LEN];
   int                                   window_total;
   logic [pwi_pkg::DATA_W-1:0]           gain_p;
   logic [pwi_pkg::DATA_W-1:0]           gain_i;
   logic [pwi_pkg::DATA_W-1:0]           gain_d;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int fail_count = 0;
   int checked_count = 0;
   int clear_count = 0;
   int setting_count = 0;

   pid_windowed_integral #(.WINDOW_LEN(WINDOW_LEN)) DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_target_value   (req_target_value),
      .req_measured_value (req_measured_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_control_value  (rsp_control_value),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      foreach (err_hist[i]) err_hist[i] = '0;
      window_total = 0;
      gain_p = '0;
      gain_i = '0;
      gain_d = '0;
   end

   // error history, window sum and PID sum for one accepted request
   function automatic void predict_control(request_type rq);
      logic signed [pwi_pkg::DATA_W-1:0] err;
      logic signed [pwi_pkg::DATA_W-1:0] deriv;
      int                                acc;
      if (rq.op == pwi_pkg::OP_CLEAR) begin
         foreach (err_hist[i]) err_hist[i] = '0;
         window_total = 0;
         return;
      end
      err = rq.measured - rq.target;
      window_total = window_total + err - err_hist[WINDOW_LEN-1];
      deriv = (err_hist[0] != 0) ? err - err_hist[0] : '0;
      acc = int'(gain_p) * err + int'(gain_i) * window_total + int'(gain_d) * deriv;
      for (int i = WINDOW_LEN - 1; i > 0; i--) err_hist[i] = err_hist[i-1];
      err_hist[0] = err;
      expected_controls.push_back(acc);
   endfunction

   function automatic request_type make_random_request();
      request_type rq;
      int          pick;
      int          delta;
      pick = $urandom_range(99);
      rq.target = pwi_pkg::DATA_W'($urandom);
      rq.measured = pwi_pkg::DATA_W'($urandom);
      rq.op = pwi_pkg::OP_COMPUTE;
      if (pick < 8) begin
         rq.op = pwi_pkg::OP_CLEAR;
      end else if (pick < 23) begin
         rq.measured = rq.target;
      end else if (pick < 63) begin
         delta = int'($urandom_range(600)) - 300;
         rq.measured = rq.target + pwi_pkg::DATA_W'(delta);
      end
      return rq;
   endfunction

   task automatic push_request(input logic op, input logic [pwi_pkg::DATA_W-1:0] target,
                               input logic [pwi_pkg::DATA_W-1:0] measured);
      request_type rq;
      rq.op = op;
      rq.target = target;
      rq.measured = measured;
      pending_requests.push_back(rq);
   endtask

   task automatic csr_write(input logic [pwi_pkg::ADDR_W-1:0] addr,
                            input logic [pwi_pkg::CSR_W-1:0] data);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (addr)
         ADDR_GAIN_P: gain_p = data[pwi_pkg::DATA_W-1:0];
         ADDR_GAIN_I: gain_i = data[pwi_pkg::DATA_W-1:0];
         ADDR_GAIN_D: gain_d = data[pwi_pkg::DATA_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_gains(input logic [pwi_pkg::DATA_W-1:0] p,
                            input logic [pwi_pkg::DATA_W-1:0] i,
                            input logic [pwi_pkg::DATA_W-1:0] d);
      csr_write(ADDR_GAIN_P, {16'($urandom), p});
      csr_write(ADDR_GAIN_I, {16'($urandom), i});
      csr_write(ADDR_GAIN_D, {16'($urandom), d});
      setting_count++;
   endtask

   // hold until every request is sent and every control value is back
   task automatic wait_idle();
      while (pending_requests.size() != 0 || req_valid || expected_controls.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic run_phase(input logic [pwi_pkg::DATA_W-1:0] p,
                            input logic [pwi_pkg::DATA_W-1:0] i,
                            input logic [pwi_pkg::DATA_W-1:0] d, input int count,
                            input int send_pct, input int recv_pct);
      set_gains(p, i, d);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (count) pending_requests.push_back(make_random_request());
      wait_idle();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_control('{req_operation, req_target_value, req_measured_value});
            if (req_operation == pwi_pkg::OP_CLEAR) clear_count++;
         end
         if (!req_valid || req_ready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_req = pending_requests.pop_front();
               req_valid <= 1'b1;
               req_operation <= next_req.op;
               req_target_value <= next_req.target;
               req_measured_value <= next_req.measured;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_controls.size() == 0) begin
               if (fail_count < 50)
                  $display("%0t: unexpected control_value, expected none, actual %0d",
                           $time, rsp_control_value);
               fail_count++;
            end else begin
               want = expected_controls.pop_front();
               if (rsp_control_value !== want) begin
                  if (fail_count < 50)
                     $display("%0t: control_value expected %0d actual %0d",
                              $time, want, rsp_control_value);
                  fail_count++;
               end
               checked_count++;
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF);
      csr_write(ADDR_UNMAPPED, 32'h0000_1234);
      send_idle_pct = 23;
      recv_idle_pct = 53;
      push_request(pwi_pkg::OP_COMPUTE, 16'h0000, 16'h0000);
      push_request(pwi_pkg::OP_COMPUTE, 16'h0000, 16'hFFFF);
      push_request(pwi_pkg::OP_COMPUTE, 16'hFFFF, 16'h0000);
      push_request(pwi_pkg::OP_COMPUTE, 16'h0000, 16'h7FFF);
      push_request(pwi_pkg::OP_COMPUTE, 16'h0000, 16'h8000);
      push_request(pwi_pkg::OP_COMPUTE, 16'h8000, 16'h0000);
      push_request(pwi_pkg::OP_COMPUTE, 16'h7FFF, 16'h8000);
      push_request(pwi_pkg::OP_COMPUTE, 16'hFFFF, 16'hFFFF);
      push_request(pwi_pkg::OP_COMPUTE, 16'h1234, 16'h1200);
      push_request(pwi_pkg::OP_CLEAR, 16'hFFFF, 16'hFFFF);
      push_request(pwi_pkg::OP_COMPUTE, 16'h0001, 16'h0003);
      push_request(pwi_pkg::OP_COMPUTE, 16'h0001, 16'h0005);
      push_request(pwi_pkg::OP_CLEAR, 16'h0000, 16'h0000);
      push_request(pwi_pkg::OP_CLEAR, 16'hA5A5, 16'h5A5A);
      repeat (10) push_request(pwi_pkg::OP_COMPUTE, 16'h0000, 16'h7FFF);
      push_request(pwi_pkg::OP_COMPUTE, 16'h7FFF, 16'h0000);
      wait_idle();

      run_phase(16'($urandom), 16'($urandom), 16'($urandom), 230, 23, 53);
      run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 230, 23, 53);
      run_phase(16'h0000, 16'h0000, 16'h0000, 230, 53, 23);
      run_phase(16'($urandom_range(500)), 16'($urandom_range(500)),
                16'($urandom_range(500)), 230, 53, 23);
      run_phase(16'hFFFF, 16'h0000, 16'hFFFF, 230, 0, 0);
      run_phase(16'($urandom), 16'($urandom), 16'($urandom), 230, 0, 0);

      $display("summary: %0d control values checked, %0d clear requests, %0d gain settings",
               checked_count, clear_count, setting_count);
      if (fail_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d control values outstanding", expected_controls.size());
      $display("tb: FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/pwi_pkg.sv
sv/pwi_csr.sv
sv/pwi_front.sv
sv/pwi_mac.sv
sv/pid_windowed_integral.sv
tb/sv/tb.sv
